// ===== rtl/core/nmm_pkg.sv =====
`default_nettype none

package nmm_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int THREADS_DEF = 8;
    localparam int WORD_W      = 32;
    localparam int MSG_W       = 4 * WORD_W;

    // operation codes
    localparam logic [2:0] FN_REG   = 3'd0;
    localparam logic [2:0] FN_UNREG = 3'd1;
    localparam logic [2:0] FN_SEND  = 3'd2;
    localparam logic [2:0] FN_RECV  = 3'd3;
    localparam logic [2:0] FN_CHECK = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NREG  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // result builder selects
    localparam logic [2:0] RES_OK    = 3'd0;
    localparam logic [2:0] RES_NREG  = 3'd1;
    localparam logic [2:0] RES_FULL  = 3'd2;
    localparam logic [2:0] RES_EMPTY = 3'd3;
    localparam logic [2:0] RES_MSG   = 3'd4;
    localparam logic [2:0] RES_PEND  = 3'd5;

    // scan targets
    localparam logic TGT_NAMES = 1'b0;
    localparam logic TGT_SLOTS = 1'b1;

    typedef struct packed {
        logic [2:0]        func;
        logic [2:0]        thread_id;
        logic [WORD_W-1:0] thread_name;
        logic [WORD_W-1:0] msg_source;
        logic [WORD_W-1:0] msg_destination;
        logic [WORD_W-1:0] msg_data;
        logic [WORD_W-1:0] msg_size;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] got_source;
        logic [WORD_W-1:0] got_destination;
        logic [WORD_W-1:0] got_data;
        logic [WORD_W-1:0] got_size;
        logic              pending;
    } t_out;

    typedef struct packed {
        logic       req_load;
        logic       name_wr;
        logic       name_clr;
        logic       name_rd;
        logic       mine_load;
        logic       scan_clr;
        logic       scan_tgt;
        logic       scan_step;
        logic       slot_wr;
        logic       slot_clr;
        logic       res_set;
        logic [2:0] res_kind;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       tid_ok;
        logic       name_set;
        logic       dst_zero;
        logic       mine_zero;
        logic       hit;
        logic       free_hit;
        logic       scan_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/nmm_ram.sv =====
`default_nettype none

module nmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/nmm_dpath.sv =====
`default_nettype none

module nmm_dpath #(
    parameter int SLOTS   = nmm_pkg::SLOTS_DEF,
    parameter int THREADS = nmm_pkg::THREADS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nmm_pkg::t_in  i_in,
    input  nmm_pkg::t_cmd i_cmd,
    output nmm_pkg::t_sts o_sts,
    output nmm_pkg::t_out o_out
);

    import nmm_pkg::*;

    localparam int TAW  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int SAW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAXN = (SLOTS > THREADS) ? SLOTS : THREADS;
    localparam int CW   = $clog2(MAXN + 1);
    localparam logic [CW-1:0] T_LIM = CW'(THREADS);
    localparam logic [CW-1:0] S_LIM = CW'(SLOTS);

    t_in                r_req;
    t_out               r_res;
    t_out               r_out;
    t_out               n_res;
    logic [THREADS-1:0] r_name_vld;
    logic [SLOTS-1:0]   r_slot_vld;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic               r_tgt;
    logic [WORD_W-1:0]  r_mine;

    logic [TAW-1:0]     w_tid_a;
    logic               w_tid_ok;
    logic [CW-1:0]      w_lim;
    logic               w_at_end;
    logic               w_name_re;
    logic [TAW-1:0]     w_name_raddr;
    logic [WORD_W-1:0]  w_name_rdata;
    logic               w_slot_re;
    logic [MSG_W-1:0]   w_slot_wdata;
    logic [MSG_W-1:0]   w_slot_rdata;
    logic [WORD_W-1:0]  w_s_src;
    logic [WORD_W-1:0]  w_s_dst;
    logic [WORD_W-1:0]  w_s_dat;
    logic [WORD_W-1:0]  w_s_sz;
    logic               w_name_hit;
    logic               w_slot_hit;

    assign w_tid_a  = TAW'(r_req.thread_id);
    assign w_tid_ok = {29'd0, r_req.thread_id} < 32'(THREADS);
    assign w_lim    = (r_tgt == TGT_SLOTS) ? S_LIM : T_LIM;
    assign w_at_end = (r_idx == w_lim);

    assign w_name_re    = i_cmd.name_rd
                        || (i_cmd.scan_step && (r_tgt == TGT_NAMES) && !w_at_end);
    assign w_name_raddr = i_cmd.name_rd ? w_tid_a : r_idx[TAW-1:0];

    nmm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (THREADS)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.name_wr),
        .i_waddr (w_tid_a),
        .i_wdata (r_req.thread_name),
        .i_re    (w_name_re),
        .i_raddr (w_name_raddr),
        .o_rdata (w_name_rdata)
    );

    assign w_slot_re    = i_cmd.scan_step && (r_tgt == TGT_SLOTS) && !w_at_end;
    assign w_slot_wdata = {r_req.msg_source, r_req.msg_destination,
                           r_req.msg_data, r_req.msg_size};

    nmm_ram #(
        .WIDTH (MSG_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.slot_wr),
        .i_waddr (r_idx[SAW-1:0]),
        .i_wdata (w_slot_wdata),
        .i_re    (w_slot_re),
        .i_raddr (r_idx[SAW-1:0]),
        .o_rdata (w_slot_rdata)
    );

    assign w_s_src = w_slot_rdata[4*WORD_W-1:3*WORD_W];
    assign w_s_dst = w_slot_rdata[3*WORD_W-1:2*WORD_W];
    assign w_s_dat = w_slot_rdata[2*WORD_W-1:WORD_W];
    assign w_s_sz  = w_slot_rdata[WORD_W-1:0];

    // RAM read data is registered along with r_rd_idx; compare against r_rd_idx, not r_idx
    assign w_name_hit = r_rd_vld && (r_tgt == TGT_NAMES)
                      && r_name_vld[r_rd_idx[TAW-1:0]]
                      && (w_name_rdata == r_req.msg_destination);
    assign w_slot_hit = r_rd_vld && (r_tgt == TGT_SLOTS)
                      && r_slot_vld[r_rd_idx[SAW-1:0]]
                      && (w_s_dst == r_mine);

    always_comb begin
        o_sts           = '0;
        o_sts.func      = r_req.func;
        o_sts.tid_ok    = w_tid_ok;
        o_sts.name_set  = w_tid_ok && r_name_vld[w_tid_a];
        o_sts.dst_zero  = (r_req.msg_destination == '0);
        o_sts.mine_zero = (w_name_rdata == '0);
        o_sts.hit       = w_name_hit || w_slot_hit;
        o_sts.free_hit  = (r_tgt == TGT_SLOTS) && !w_at_end
                        && !r_slot_vld[r_idx[SAW-1:0]];
        o_sts.scan_done = w_at_end;
    end

    always_comb begin
        n_res = '0;
        case (i_cmd.res_kind)
            RES_OK: begin
                n_res.status = ST_OK;
            end
            RES_NREG: begin
                n_res.status = ST_NREG;
            end
            RES_FULL: begin
                n_res.status = ST_FULL;
            end
            RES_EMPTY: begin
                n_res.status = ST_EMPTY;
            end
            RES_MSG: begin
                n_res.status          = ST_OK;
                n_res.got_source      = w_s_src;
                n_res.got_destination = w_s_dst;
                n_res.got_data        = w_s_dat;
                n_res.got_size        = w_s_sz;
            end
            RES_PEND: begin
                n_res.status  = ST_OK;
                n_res.pending = 1'b1;
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_vld <= '0;
            r_slot_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cmd.name_wr) begin
                r_name_vld[w_tid_a] <= 1'b1;
            end
            if (i_cmd.name_clr) begin
                r_name_vld[w_tid_a] <= 1'b0;
            end
            if (i_cmd.slot_wr) begin
                r_slot_vld[r_idx[SAW-1:0]] <= 1'b1;
            end
            if (i_cmd.slot_clr) begin
                r_slot_vld[r_rd_idx[SAW-1:0]] <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= !w_at_end;
            end else begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_in;
        end
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
            r_tgt <= i_cmd.scan_tgt;
        end else if (i_cmd.scan_step && !w_at_end) begin
            r_idx    <= r_idx + CW'(1);
            r_rd_idx <= r_idx;
        end
        if (i_cmd.mine_load) begin
            r_mine <= w_name_rdata;
        end
        if (i_cmd.res_set) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out = r_out;

    a_slot_wr_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.slot_wr |-> (!w_at_end && !r_slot_vld[r_idx[SAW-1:0]]))
        else $error("slot write to an occupied slot");

    a_name_wr_tid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.name_wr || i_cmd.name_clr) |-> w_tid_ok)
        else $error("name table update with thread index out of range");

    a_slot_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.slot_clr && !i_cmd.slot_wr) |=> !r_slot_vld[$past(r_rd_idx[SAW-1:0])])
        else $error("received slot still marked valid");

endmodule

`default_nettype wire

// ===== rtl/core/nmm_ctrl.sv =====
`default_nettype none

module nmm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  nmm_pkg::t_sts i_sts,
    output nmm_pkg::t_cmd o_cmd
);

    import nmm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_TSCAN  = 3'd2;
    localparam logic [2:0] S_FREE   = 3'd3;
    localparam logic [2:0] S_MINE   = 3'd4;
    localparam logic [2:0] S_SSCAN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_vld;
    logic       w_is_recv;
    logic       w_out_free;

    assign w_is_recv  = (i_sts.func == FN_RECV);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res_kind = RES_OK;
                case (i_sts.func)
                    FN_REG: begin
                        o_cmd.name_wr = i_sts.tid_ok;
                        o_cmd.res_set = 1'b1;
                        n_state       = S_DONE;
                    end
                    FN_UNREG: begin
                        o_cmd.name_clr = i_sts.tid_ok;
                        o_cmd.res_set  = 1'b1;
                        n_state        = S_DONE;
                    end
                    FN_SEND: begin
                        if (i_sts.dst_zero) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = RES_NREG;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.scan_clr = 1'b1;
                            o_cmd.scan_tgt = TGT_NAMES;
                            n_state        = S_TSCAN;
                        end
                    end
                    FN_RECV, FN_CHECK: begin
                        if (!i_sts.name_set) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = w_is_recv ? RES_EMPTY : RES_OK;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.name_rd = 1'b1;
                            n_state       = S_MINE;
                        end
                    end
                    default: begin
                        o_cmd.res_set = 1'b1;
                        n_state       = S_DONE;
                    end
                endcase
            end
            S_TSCAN: begin
                if (i_sts.hit) begin
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.scan_tgt = TGT_SLOTS;
                    n_state        = S_FREE;
                end else if (i_sts.scan_done) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RES_NREG;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FREE: begin
                if (i_sts.free_hit) begin
                    o_cmd.slot_wr  = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RES_OK;
                    n_state        = S_DONE;
                end else if (i_sts.scan_done) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RES_FULL;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_MINE: begin
                // a registered zero name counts as no name
                if (i_sts.mine_zero) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = w_is_recv ? RES_EMPTY : RES_OK;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.mine_load = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    o_cmd.scan_tgt  = TGT_SLOTS;
                    n_state         = S_SSCAN;
                end
            end
            S_SSCAN: begin
                if (i_sts.hit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = w_is_recv ? RES_MSG : RES_PEND;
                    o_cmd.slot_clr = w_is_recv;
                    n_state        = S_DONE;
                end else if (i_sts.scan_done) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = w_is_recv ? RES_EMPTY : RES_OK;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                // hold until the output register frees up
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted transfer not decoded");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_state == S_IDLE && r_out_vld))
        else $error("finished result not moved to output register");

    a_scan_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SSCAN && i_sts.hit) |=> (r_state == S_DONE))
        else $error("slot scan ran past the first match");

endmodule

`default_nettype wire

// ===== rtl/core/named_message_mailbox_core.sv =====
// Register, unregister and unused codes go from decode straight to done; send scans the name
// table, then the slot table for a free slot; receive and check fetch the caller's name and
// then scan the slot table. One operation at a time; the name scan and the slot scan, one entry
// per cycle through the single read port of each table RAM, set the rate.
// A new transfer is taken while the previous result waits in the output register.
// Synchronous active-low reset clears the name and slot valid bits; RAM contents are kept.
`default_nettype none

module named_message_mailbox_core #(
    parameter int SLOTS   = nmm_pkg::SLOTS_DEF,
    parameter int THREADS = nmm_pkg::THREADS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  nmm_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output nmm_pkg::t_out o_out
);

    import nmm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    nmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    nmm_dpath #(
        .SLOTS   (SLOTS),
        .THREADS (THREADS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
